[hdl/occ_pkg.sv]
// Shared widths, register indexes, test bit positions and structs of the convergence check.
package occ_pkg;

  localparam int DATA_W   = 48;            // signed position and gradient elements
  localparam int DIFF_W   = DATA_W + 1;    // displacement before taking the magnitude
  localparam int MAG_W    = 48;            // magnitudes of gradient and displacement
  localparam int HALF_W   = MAG_W / 2;     // multiplier operand split
  localparam int PP_W     = 2 * HALF_W;    // partial product width
  localparam int PROD_W   = 2 * MAG_W;     // full product width
  localparam int ACC_W    = 64;            // accumulator width
  localparam int BND_W    = 47;            // bound register width
  localparam int TEST_N   = 5;             // number of tests
  localparam int CNT_W    = 3;             // pass and fail count width
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GRAD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_GRAD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_DISP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DOT       = 3'd5;

  // Test bit positions in the masks
  localparam int T_MAX_GRAD  = 0;
  localparam int T_NORM_GRAD = 1;
  localparam int T_MAX_DISP  = 2;
  localparam int T_NORM_DISP = 3;
  localparam int T_DOT       = 4;

  localparam logic [TEST_N-1:0] ENABLE_RESET = 5'd21;

  localparam logic [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Per-item flags and magnitudes that travel along the product pipeline
  typedef struct packed {
    logic             hp;
    logic             hg;
    logic             last;
    logic             neg;
    logic [MAG_W-1:0] ag;
    logic [MAG_W-1:0] ad;
  } side_t;

  // Metrics of one finished vector
  typedef struct packed {
    logic [MAG_W-1:0] max_g;
    logic [MAG_W-1:0] max_d;
    logic [ACC_W-1:0] ssg;
    logic [ACC_W-1:0] ssd;
    logic [ACC_W-1:0] sgd;
    logic             hp;
    logic             hg;
  } fin_t;

  // Bounds as the tests see them
  typedef struct packed {
    logic [TEST_N-1:0] enable;
    logic [BND_W-1:0]  grad_peak_lim;
    logic [BND_W-1:0]  disp_peak_lim;
    logic [BND_W-1:0]  dot;
    logic [ACC_W-1:0]  norm_grad_thr;
    logic [ACC_W-1:0]  norm_disp_thr;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic              converged;
    logic              no_test_error;
    logic [TEST_N-1:0] applied_mask;
    logic [TEST_N-1:0] pass_mask;
    logic [CNT_W-1:0]  pass_count;
    logic [CNT_W-1:0]  fail_count;
  } res_t;

endpackage

[hdl/occ_in_if.sv]
// Input channel: one vector element per item.
interface occ_in_if;
  import occ_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] pos_old;
  logic [DATA_W-1:0] pos_new;
  logic [DATA_W-1:0] grad;
  logic              have_pos;
  logic              have_grad;
  logic              last;

  modport source (output valid, output pos_old, output pos_new, output grad,
                  output have_pos, output have_grad, output last, input ready);
  modport sink   (input valid, input pos_old, input pos_new, input grad,
                  input have_pos, input have_grad, input last, output ready);
endinterface

[hdl/occ_out_if.sv]
// Result channel: one verdict item per vector.
interface occ_out_if;
  import occ_pkg::*;

  logic              valid;
  logic              ready;
  logic              converged;
  logic              no_test_error;
  logic [TEST_N-1:0] applied_mask;
  logic [TEST_N-1:0] pass_mask;
  logic [CNT_W-1:0]  pass_count;
  logic [CNT_W-1:0]  fail_count;

  modport source (output valid, output converged, output no_test_error,
                  output applied_mask, output pass_mask, output pass_count,
                  output fail_count, input ready);
  modport sink   (input valid, input converged, input no_test_error,
                  input applied_mask, input pass_mask, input pass_count,
                  input fail_count, output ready);
endinterface

[hdl/occ_scaled_mul.sv]
// Three-stage unsigned multiplier: (a*b) >> FRAC_BITS, saturated to 64 bits.
module occ_scaled_mul #(
  parameter int FRAC_BITS = 40
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [occ_pkg::MAG_W-1:0] a,
  input  logic [occ_pkg::MAG_W-1:0] b,
  output logic [occ_pkg::ACC_W-1:0] p
);
  import occ_pkg::*;

  logic [HALF_W-1:0] a_lo, a_hi, b_lo, b_hi;
  logic [PP_W-1:0]   pll_r, plh_r, phl_r, phh_r;
  logic [PROD_W-1:0] mid, prod_nxt, prod_r, sh;
  logic [ACC_W-1:0]  p_nxt, p_r;

  assign a_lo = a[HALF_W-1:0];
  assign a_hi = a[MAG_W-1:HALF_W];
  assign b_lo = b[HALF_W-1:0];
  assign b_hi = b[MAG_W-1:HALF_W];

  // Combine partial products into the full product
  assign mid      = PROD_W'(plh_r) + PROD_W'(phl_r);
  assign prod_nxt = PROD_W'(pll_r) + (mid << HALF_W) + (PROD_W'(phh_r) << MAG_W);

  // Drop fraction bits, saturate anything above 64 bits
  assign sh    = prod_r >> FRAC_BITS;
  assign p_nxt = (|sh[PROD_W-1:ACC_W]) ? {ACC_W{1'b1}} : sh[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r  <= PP_W'(a_lo) * PP_W'(b_lo);
      plh_r  <= PP_W'(a_lo) * PP_W'(b_hi);
      phl_r  <= PP_W'(a_hi) * PP_W'(b_lo);
      phh_r  <= PP_W'(a_hi) * PP_W'(b_hi);
      prod_r <= prod_nxt;
      p_r    <= p_nxt;
    end
  end

  assign p = p_r;
endmodule

[hdl/occ_accum.sv]
// Metric accumulators and the snapshot of a finished vector.
module occ_accum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      vld,
  input  occ_pkg::side_t            side,
  input  logic [occ_pkg::ACC_W-1:0] sq_g,
  input  logic [occ_pkg::ACC_W-1:0] sq_d,
  input  logic [occ_pkg::ACC_W-1:0] dot_m,
  output logic                      fin_v,
  output occ_pkg::fin_t             fin
);
  import occ_pkg::*;

  logic [MAG_W-1:0] max_g_r, max_d_r, max_g_nxt, max_d_nxt;
  logic [ACC_W-1:0] ssg_r, ssd_r, sgd_r, ssg_nxt, ssd_nxt, sgd_nxt;
  logic [ACC_W:0]   ssg_sum, ssd_sum, sgd_sum;
  logic [ACC_W-1:0] dot_c, dot_t;
  logic             fin_v_r;
  fin_t             fin_r;

  // Clamp the dot term magnitude and apply its sign
  assign dot_c = dot_m[ACC_W-1] ? S64_MAX : dot_m;
  assign dot_t = side.neg ? (~dot_c + 1'b1) : dot_c;

  assign ssg_sum = {1'b0, ssg_r} + {1'b0, sq_g};
  assign ssd_sum = {1'b0, ssd_r} + {1'b0, sq_d};
  assign sgd_sum = {sgd_r[ACC_W-1], sgd_r} + {dot_t[ACC_W-1], dot_t};

  // Fold this element into the running metrics
  always_comb begin
    max_g_nxt = max_g_r;
    max_d_nxt = max_d_r;
    ssg_nxt   = ssg_r;
    ssd_nxt   = ssd_r;
    sgd_nxt   = sgd_r;
    if (side.hg) begin
      if (side.ag > max_g_r) max_g_nxt = side.ag;
      ssg_nxt = ssg_sum[ACC_W] ? {ACC_W{1'b1}} : ssg_sum[ACC_W-1:0];
    end
    if (side.hp) begin
      if (side.ad > max_d_r) max_d_nxt = side.ad;
      ssd_nxt = ssd_sum[ACC_W] ? {ACC_W{1'b1}} : ssd_sum[ACC_W-1:0];
    end
    if (side.hp && side.hg) begin
      if (sgd_sum[ACC_W] != sgd_sum[ACC_W-1]) begin
        sgd_nxt = sgd_sum[ACC_W] ? S64_MIN : S64_MAX;
      end else begin
        sgd_nxt = sgd_sum[ACC_W-1:0];
      end
    end
  end

  // Hold on stall; snapshot and clear on the last element
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_g_r <= '0;
      max_d_r <= '0;
      ssg_r   <= '0;
      ssd_r   <= '0;
      sgd_r   <= '0;
      fin_v_r <= 1'b0;
    end else if (adv) begin
      fin_v_r <= vld && side.last;
      if (vld && side.last) begin
        max_g_r <= '0;
        max_d_r <= '0;
        ssg_r   <= '0;
        ssd_r   <= '0;
        sgd_r   <= '0;
      end else if (vld) begin
        max_g_r <= max_g_nxt;
        max_d_r <= max_d_nxt;
        ssg_r   <= ssg_nxt;
        ssd_r   <= ssd_nxt;
        sgd_r   <= sgd_nxt;
      end
    end
  end

  // Snapshot payload
  always_ff @(posedge clk) begin
    if (adv && vld && side.last) begin
      fin_r.max_g <= max_g_nxt;
      fin_r.max_d <= max_d_nxt;
      fin_r.ssg   <= ssg_nxt;
      fin_r.ssd   <= ssd_nxt;
      fin_r.sgd   <= sgd_nxt;
      fin_r.hp    <= side.hp;
      fin_r.hg    <= side.hg;
    end
  end

  assign fin_v = fin_v_r;
  assign fin   = fin_r;
endmodule

[hdl/occ_judge.sv]
// Compare finished metrics with their bounds and form the verdict.
module occ_judge (
  input  occ_pkg::fin_t fin,
  input  occ_pkg::cfg_t cfg,
  output occ_pkg::res_t res
);
  import occ_pkg::*;

  logic [TEST_N-1:0] applicable, applied, in_bound;
  logic [ACC_W-1:0]  abs_sgd;
  logic [CNT_W-1:0]  np, nf;

  assign abs_sgd = fin.sgd[ACC_W-1] ? (~fin.sgd + 1'b1) : fin.sgd;

  // Decide applicability and per-test pass
  always_comb begin
    applicable              = '0;
    applicable[T_MAX_GRAD]  = fin.hg;
    applicable[T_NORM_GRAD] = fin.hg;
    applicable[T_MAX_DISP]  = fin.hp;
    applicable[T_NORM_DISP] = fin.hp;
    applicable[T_DOT]       = fin.hp && fin.hg;
    applied                 = applicable & cfg.enable;

    in_bound              = '0;
    in_bound[T_MAX_GRAD]  = fin.max_g <= MAG_W'(cfg.grad_peak_lim);
    in_bound[T_NORM_GRAD] = fin.ssg <= cfg.norm_grad_thr;
    in_bound[T_MAX_DISP]  = fin.max_d <= MAG_W'(cfg.disp_peak_lim);
    in_bound[T_NORM_DISP] = fin.ssd <= cfg.norm_disp_thr;
    in_bound[T_DOT]       = abs_sgd <= ACC_W'(cfg.dot);
  end

  // Count passes and failures
  always_comb begin
    np = '0;
    nf = '0;
    for (int i = 0; i < TEST_N; i++) begin
      if (applied[i]) begin
        if (in_bound[i]) np = np + 1'b1;
        else nf = nf + 1'b1;
      end
    end
  end

  assign res.converged     = (applied != '0) && (nf == '0);
  assign res.no_test_error = (applied == '0);
  assign res.applied_mask  = applied;
  assign res.pass_mask     = applied & in_bound;
  assign res.pass_count    = np;
  assign res.fail_count    = nf;
endmodule

[hdl/optimizer_convergence_check.sv]
// A result follows the last element through the input, side and multiplier registers,
// the accumulator snapshot and the result register. Throughput: one element per cycle
// while not stalled; the product pipeline (three stages) and the accumulate stage
// advance together. A stall happens only while a finished verdict and an untaken
// result both wait. Reset (synchronous, active low) clears accumulators, valid flags
// and loads register defaults; norm thresholds settle after reset or a bound write.
module optimizer_convergence_check #(
  parameter int FRAC_BITS = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  occ_in_if.sink                        in_ch,
  occ_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [occ_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [occ_pkg::BND_W-1:0]     cfg_wdata
);
  import occ_pkg::*;

  localparam longint unsigned TOL_FULL =
    ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic [BND_W-1:0] TOL_RESET = BND_W'(TOL_FULL);

  // Configuration registers
  logic [TEST_N-1:0] enable_r;
  logic [BND_W-1:0]  max_grad_r, norm_grad_r, max_disp_r, norm_disp_r, dot_r;
  logic [ACC_W-1:0]  norm_grad_thr, norm_disp_thr;
  cfg_t              cfg;

  // Pipeline
  logic                     adv;
  logic [4:0]               v_r;
  logic [DATA_W-1:0]        po_r, pn_r, g_r;
  logic                     hp0_r, hg0_r, last0_r;
  logic signed [DIFF_W-1:0] d_s;
  logic [DIFF_W-1:0]        ad_full;
  side_t                    side1_nxt;
  side_t                    side_r [1:4];
  logic [ACC_W-1:0]         sq_g, sq_d, dot_m;
  logic                     fin_v;
  fin_t                     fin;
  res_t                     res;
  res_t                     out_r;
  logic                     out_valid_r;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= ENABLE_RESET;
      max_grad_r  <= TOL_RESET;
      norm_grad_r <= '0;
      max_disp_r  <= TOL_RESET;
      norm_disp_r <= '0;
      dot_r       <= TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:    enable_r    <= cfg_wdata[TEST_N-1:0];
        REG_MAX_GRAD:  max_grad_r  <= cfg_wdata;
        REG_NORM_GRAD: norm_grad_r <= cfg_wdata;
        REG_MAX_DISP:  max_disp_r  <= cfg_wdata;
        REG_NORM_DISP: norm_disp_r <= cfg_wdata;
        REG_DOT:       dot_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Square the norm bounds into their thresholds; these multipliers always run
  occ_scaled_mul #(.FRAC_BITS(FRAC_BITS)) u_thr_grad (
    .clk(clk), .en(1'b1),
    .a(MAG_W'(norm_grad_r)), .b(MAG_W'(norm_grad_r)), .p(norm_grad_thr)
  );
  occ_scaled_mul #(.FRAC_BITS(FRAC_BITS)) u_thr_disp (
    .clk(clk), .en(1'b1),
    .a(MAG_W'(norm_disp_r)), .b(MAG_W'(norm_disp_r)), .p(norm_disp_thr)
  );

  assign cfg.enable        = enable_r;
  assign cfg.grad_peak_lim = max_grad_r;
  assign cfg.disp_peak_lim = max_disp_r;
  assign cfg.dot           = dot_r;
  assign cfg.norm_grad_thr = norm_grad_thr;
  assign cfg.norm_disp_thr = norm_disp_thr;

  // Stall only when a verdict cannot leave
  assign adv         = !(fin_v && out_valid_r && !out_ch.ready);
  assign in_ch.ready = adv;

  // Valid flags along the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_ch.valid};
    end
  end

  // Register the input item
  always_ff @(posedge clk) begin
    if (adv) begin
      po_r    <= in_ch.pos_old;
      pn_r    <= in_ch.pos_new;
      g_r     <= in_ch.grad;
      hp0_r   <= in_ch.have_pos;
      hg0_r   <= in_ch.have_grad;
      last0_r <= in_ch.last;
    end
  end

  // Displacement, magnitudes and dot sign
  assign d_s     = $signed({pn_r[DATA_W-1], pn_r}) - $signed({po_r[DATA_W-1], po_r});
  assign ad_full = d_s[DIFF_W-1] ? DIFF_W'(-d_s) : DIFF_W'(d_s);

  always_comb begin
    side1_nxt.hp   = hp0_r;
    side1_nxt.hg   = hg0_r;
    side1_nxt.last = last0_r;
    side1_nxt.neg  = g_r[DATA_W-1] ^ d_s[DIFF_W-1];
    side1_nxt.ag   = g_r[DATA_W-1] ? MAG_W'(~g_r + 1'b1) : MAG_W'(g_r);
    side1_nxt.ad   = ad_full[MAG_W-1:0];
  end

  // Advance flags and magnitudes alongside the products
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[1] <= side1_nxt;
      for (int i = 2; i <= 4; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Element products
  occ_scaled_mul #(.FRAC_BITS(FRAC_BITS)) u_sq_grad (
    .clk(clk), .en(adv), .a(side_r[1].ag), .b(side_r[1].ag), .p(sq_g)
  );
  occ_scaled_mul #(.FRAC_BITS(FRAC_BITS)) u_sq_disp (
    .clk(clk), .en(adv), .a(side_r[1].ad), .b(side_r[1].ad), .p(sq_d)
  );
  occ_scaled_mul #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk(clk), .en(adv), .a(side_r[1].ag), .b(side_r[1].ad), .p(dot_m)
  );

  occ_accum u_accum (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld(v_r[4]), .side(side_r[4]),
    .sq_g(sq_g), .sq_d(sq_d), .dot_m(dot_m), .fin_v(fin_v), .fin(fin)
  );

  occ_judge u_judge (
    .fin(fin), .cfg(cfg), .res(res)
  );

  // Result register: drop when taken, load a new verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && fin_v) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_v) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.converged     = out_r.converged;
  assign out_ch.no_test_error = out_r.no_test_error;
  assign out_ch.applied_mask  = out_r.applied_mask;
  assign out_ch.pass_mask     = out_r.pass_mask;
  assign out_ch.pass_count    = out_r.pass_count;
  assign out_ch.fail_count    = out_r.fail_count;

`ifndef SYNTHESIS
  // A new result comes only from a finished verdict
  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fin_v && adv))
    else $error("result raised without a finished verdict");

  // The pipeline stalls only on a blocked verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> (fin_v && out_valid_r))
    else $error("pipeline stalled without a waiting verdict");

  // Counts agree with the applied tests
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_r.pass_count) + 32'(out_r.fail_count)
                     == 32'($countones(out_r.applied_mask))))
    else $error("pass and fail counts disagree with applied mask");

  // Converged and no-test error exclude each other
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.converged && out_r.no_test_error))
    else $error("converged set together with no-test error");
`endif

endmodule

[bench/optimizer_convergence_check_tb.sv]
// Self-checking testbench for optimizer_convergence_check: directed, saturation and random vectors.
module optimizer_convergence_check_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import occ_pkg::*;

  localparam int FRAC = 40;
  localparam logic [BND_W-1:0] TOL_DEFAULT =
    BND_W'(((64'd1 << FRAC) + 64'd500000) / 64'd1000000);
  localparam logic [BND_W-1:0] BND_MAX = {BND_W{1'b1}};
  localparam logic [DATA_W-1:0] D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] D_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] D_ONE = 1;
  localparam logic [DATA_W-1:0] D_NEG_ONE = '1;
  localparam logic signed [ACC_W:0] DOT_HI = {1'b0, S64_MAX};
  localparam logic signed [ACC_W:0] DOT_LO = {1'b1, S64_MIN};
  // Indexes past the register list
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] pos_old;
    logic [DATA_W-1:0] pos_new;
    logic [DATA_W-1:0] grad;
    logic              have_pos;
    logic              have_grad;
    logic              last;
  } elem_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BND_W-1:0] cfg_wdata;

  occ_in_if in_bus ();
  occ_out_if out_bus ();

  optimizer_convergence_check #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow registers
  logic [TEST_N-1:0] en_mask = ENABLE_RESET;
  logic [BND_W-1:0] bnd_max_grad = TOL_DEFAULT;
  logic [BND_W-1:0] bnd_norm_grad = '0;
  logic [BND_W-1:0] bnd_max_disp = TOL_DEFAULT;
  logic [BND_W-1:0] bnd_norm_disp = '0;
  logic [BND_W-1:0] bnd_dot = TOL_DEFAULT;

  // Running metrics of the vector in flight
  logic [MAG_W-1:0] run_max_g = '0;
  logic [MAG_W-1:0] run_max_d = '0;
  logic [ACC_W-1:0] run_ssg = '0;
  logic [ACC_W-1:0] run_ssd = '0;
  logic [ACC_W-1:0] run_dot = '0;

  res_t verdict_q[$];
  int src_idle_pct = 19;
  int snk_idle_pct = 80;
  int errors = 0;
  int items_sent = 0;
  int verdicts_checked = 0;

  // Clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // (a*b) >> FRAC, exact, truncated, clamped to 64 bits
  function automatic logic [ACC_W-1:0] scaled_prod(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
    logic [2*ACC_W-1:0] p;
    p = (a * b) >> FRAC;
    if (p[2*ACC_W-1:ACC_W] != 0) return '1;
    return p[ACC_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] sat_sum(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? '1 : s[ACC_W-1:0];
  endfunction

  // Fold one accepted element into the metrics; on last, queue the verdict and clear
  task automatic fold_element(elem_t e);
    logic [DIFF_W-1:0] d;
    logic [MAG_W-1:0] ag;
    logic [MAG_W-1:0] ad;
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] dot_mag;
    logic signed [ACC_W:0] term;
    logic signed [ACC_W:0] dot_sum;
    logic [TEST_N-1:0] avail;
    logic [TEST_N-1:0] applied;
    logic [TEST_N-1:0] passed;
    logic [CNT_W-1:0] np;
    logic [CNT_W-1:0] nf;
    res_t v;
    ag = e.grad[DATA_W-1] ? -e.grad : e.grad;
    d = {e.pos_new[DATA_W-1], e.pos_new} - {e.pos_old[DATA_W-1], e.pos_old};
    ad = MAG_W'(d[DIFF_W-1] ? -d : d);
    if (e.have_grad) begin
      if (ag > run_max_g) run_max_g = ag;
      run_ssg = sat_sum(run_ssg, scaled_prod(ACC_W'(ag), ACC_W'(ag)));
    end
    if (e.have_pos) begin
      if (ad > run_max_d) run_max_d = ad;
      run_ssd = sat_sum(run_ssd, scaled_prod(ACC_W'(ad), ACC_W'(ad)));
    end
    if (e.have_pos && e.have_grad) begin
      m = scaled_prod(ACC_W'(ag), ACC_W'(ad));
      if (m > S64_MAX) m = S64_MAX;
      term = {1'b0, m};
      if (e.grad[DATA_W-1] != d[DIFF_W-1]) term = -term;
      dot_sum = $signed({run_dot[ACC_W-1], run_dot}) + term;
      if (dot_sum > DOT_HI) dot_sum = DOT_HI;
      else if (dot_sum < DOT_LO) dot_sum = DOT_LO;
      run_dot = dot_sum[ACC_W-1:0];
    end
    if (!e.last) return;

    avail = '0;
    avail[T_MAX_GRAD] = e.have_grad;
    avail[T_NORM_GRAD] = e.have_grad;
    avail[T_MAX_DISP] = e.have_pos;
    avail[T_NORM_DISP] = e.have_pos;
    avail[T_DOT] = e.have_pos && e.have_grad;
    applied = avail & en_mask;
    dot_mag = run_dot[ACC_W-1] ? -run_dot : run_dot;
    passed[T_MAX_GRAD] = run_max_g <= bnd_max_grad;
    passed[T_NORM_GRAD] = run_ssg <= scaled_prod(ACC_W'(bnd_norm_grad), ACC_W'(bnd_norm_grad));
    passed[T_MAX_DISP] = run_max_d <= bnd_max_disp;
    passed[T_NORM_DISP] = run_ssd <= scaled_prod(ACC_W'(bnd_norm_disp), ACC_W'(bnd_norm_disp));
    passed[T_DOT] = dot_mag <= bnd_dot;
    passed &= applied;
    np = '0;
    nf = '0;
    for (int i = 0; i < TEST_N; i++) begin
      if (applied[i]) begin
        if (passed[i]) np++;
        else nf++;
      end
    end
    v.converged = (applied != 0) && (nf == 0);
    v.no_test_error = applied == 0;
    v.applied_mask = applied;
    v.pass_mask = passed;
    v.pass_count = np;
    v.fail_count = nf;
    verdict_q.push_back(v);
    run_max_g = '0;
    run_max_d = '0;
    run_ssg = '0;
    run_ssd = '0;
    run_dot = '0;
  endtask

  // Offer one element, hold it until taken, then predict
  task automatic send_element(elem_t e);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.pos_old <= e.pos_old;
    in_bus.pos_new <= e.pos_new;
    in_bus.grad <= e.grad;
    in_bus.have_pos <= e.have_pos;
    in_bus.have_grad <= e.have_grad;
    in_bus.last <= e.last;
    do @(posedge clk); while (!in_bus.ready);
    fold_element(e);
    items_sent++;
  endtask

  function automatic elem_t mk(logic [DATA_W-1:0] po, logic [DATA_W-1:0] pn,
                               logic [DATA_W-1:0] g, logic hp, logic hg, logic lst);
    elem_t e;
    e.pos_old = po;
    e.pos_new = pn;
    e.grad = g;
    e.have_pos = hp;
    e.have_grad = hg;
    e.last = lst;
    return e;
  endfunction

  // Drop valid, wait out every verdict, then let the pipeline empty
  task automatic quiesce();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BND_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLE:    en_mask = data[TEST_N-1:0];
      REG_MAX_GRAD:  bnd_max_grad = data;
      REG_NORM_GRAD: bnd_norm_grad = data;
      REG_MAX_DISP:  bnd_max_disp = data;
      REG_NORM_DISP: bnd_norm_disp = data;
      REG_DOT:       bnd_dot = data;
      default: ;
    endcase
  endtask

  // Write every register while idle, then let the norm thresholds settle
  task automatic load_config(logic [TEST_N-1:0] en, logic [BND_W-1:0] mg, logic [BND_W-1:0] ng,
                             logic [BND_W-1:0] md, logic [BND_W-1:0] nd, logic [BND_W-1:0] db);
    quiesce();
    write_reg(REG_ENABLE, BND_W'(en));
    write_reg(REG_MAX_GRAD, mg);
    write_reg(REG_NORM_GRAD, ng);
    write_reg(REG_MAX_DISP, md);
    write_reg(REG_NORM_DISP, nd);
    write_reg(REG_DOT, db);
    repeat (8) @(posedge clk);
  endtask

  // Mix of zero, extremes and values of random magnitude and sign
  function automatic logic [DATA_W-1:0] rand_value();
    logic [63:0] r;
    int w;
    case ($urandom_range(9))
      0: return '0;
      1: begin
        case ($urandom_range(3))
          0: return D_MAX;
          1: return D_MIN;
          2: return D_NEG_ONE;
          default: return D_ONE;
        endcase
      end
      default: begin
        w = $urandom_range(DATA_W, 1);
        r = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
        if ($urandom_range(1)) r = -r;
        return r[DATA_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [BND_W-1:0] rand_bound();
    logic [63:0] r;
    int w;
    case ($urandom_range(7))
      0: return '0;
      1: return BND_MAX;
      default: begin
        w = $urandom_range(BND_W, 1);
        r = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
        return r[BND_W-1:0];
      end
    endcase
  endfunction

  // Mostly both vectors present; the rest mixed presence
  function automatic elem_t rand_element(logic lst);
    elem_t e;
    logic [DATA_W-1:0] delta;
    e.grad = rand_value();
    e.pos_old = rand_value();
    delta = rand_value();
    e.pos_new = e.pos_old + delta;
    if ($urandom_range(9) < 7) begin
      e.have_pos = 1'b1;
      e.have_grad = 1'b1;
    end else begin
      e.have_pos = 1'($urandom_range(1));
      e.have_grad = 1'($urandom_range(1));
    end
    e.last = lst;
    return e;
  endfunction

  // Check each verdict item against the oldest prediction
  function automatic void check_field(string name, logic [TEST_N-1:0] want, logic [TEST_N-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : verdict_check
    res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (verdict_q.size() == 0) begin
        $error("verdict item with no vector pending");
        errors++;
      end else begin
        want = verdict_q.pop_front();
        verdicts_checked++;
        check_field("converged", want.converged, out_bus.converged);
        check_field("no_test_error", want.no_test_error, out_bus.no_test_error);
        check_field("applied_mask", want.applied_mask, out_bus.applied_mask);
        check_field("pass_mask", want.pass_mask, out_bus.pass_mask);
        check_field("pass_count", want.pass_count, out_bus.pass_count);
        check_field("fail_count", want.fail_count, out_bus.fail_count);
      end
    end
  end

  // Random back-pressure on the verdict channel
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Reset defaults: max bounds at one part per million, only max and dot tests on
  task automatic test_reset_defaults();
    send_element(mk('0, DATA_W'(TOL_DEFAULT), DATA_W'(TOL_DEFAULT), 1'b1, 1'b1, 1'b1));
    send_element(mk('0, '0, DATA_W'(TOL_DEFAULT) + D_ONE, 1'b1, 1'b1, 1'b1));
    send_element(mk(D_MAX, D_MIN, D_MAX, 1'b0, 1'b0, 1'b1));
  endtask

  // Field extremes, mixed presence, spare indexes, zero bounds, nothing enabled
  task automatic test_field_extremes();
    load_config('1, BND_MAX, BND_MAX, BND_MAX, BND_MAX, BND_MAX);
    write_reg(REG_SPARE_LO, '0);
    write_reg(REG_SPARE_HI, '0);
    repeat (8) @(posedge clk);
    send_element(mk(D_MIN, D_MAX, D_MIN, 1'b1, 1'b1, 1'b0));
    send_element(mk(D_MAX, D_MIN, D_MAX, 1'b1, 1'b1, 1'b0));
    send_element(mk(D_NEG_ONE, D_ONE, D_NEG_ONE, 1'b1, 1'b1, 1'b0));
    send_element(mk('0, '0, '0, 1'b1, 1'b1, 1'b1));
    send_element(mk(D_MAX, D_MIN, D_MAX, 1'b0, 1'b1, 1'b0));
    send_element(mk('0, D_MAX, '0, 1'b1, 1'b0, 1'b0));
    send_element(mk(D_ONE, 48'd2, D_NEG_ONE, 1'b0, 1'b1, 1'b1));
    send_element(mk(48'd5, -48'sd5, 48'd7, 1'b1, 1'b0, 1'b1));
    send_element(mk('0, '0, '0, 1'b0, 1'b0, 1'b1));
    load_config(5'd31, '0, '0, '0, '0, '0);
    send_element(mk('0, '0, '0, 1'b1, 1'b1, 1'b1));
    send_element(mk('0, D_ONE, D_ONE, 1'b1, 1'b1, 1'b1));
    load_config('0, BND_MAX, BND_MAX, BND_MAX, BND_MAX, BND_MAX);
    send_element(mk(D_MIN, D_MAX, D_MAX, 1'b1, 1'b1, 1'b1));
    load_config(5'b01010, 47'h100_0000_0000, '0, 47'h100_0000_0000, 47'h7F_FFFF_FFFF, '0);
    send_element(mk('0, 48'h100_0000_0000, 48'hFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0));
    send_element(mk('0, 48'h7F_FFFF_FFFF, 48'h1_0000_0000, 1'b1, 1'b1, 1'b1));
  endtask

  // Long vectors of largest magnitudes drive the sums into saturation
  task automatic test_saturation();
    load_config(5'd31, BND_MAX, BND_MAX, BND_MAX, BND_MAX, BND_MAX);
    for (int i = 0; i < 280; i++) send_element(mk(D_MIN, D_MAX, D_MAX, 1'b1, 1'b1, i == 279));
    for (int i = 0; i < 280; i++) send_element(mk(D_MIN, D_MAX, D_MIN, 1'b1, 1'b1, i == 279));
  endtask

  // Random vectors in three idling phases, with a fresh configuration per chunk
  task automatic test_random();
    int len;
    int chunk_items;
    for (int ph = 0; ph < 3; ph++) begin
      for (int ch = 0; ch < 5; ch++) begin
        if (ph == 0 && ch == 0) load_config(5'd31, '0, '0, '0, '0, '0);
        else if (ph == 0 && ch == 1) load_config(5'd31, BND_MAX, BND_MAX, BND_MAX, BND_MAX, BND_MAX);
        else load_config($urandom_range(3) == 0 ? 5'd31 : 5'($urandom_range(31)),
                         rand_bound(), rand_bound(), rand_bound(), rand_bound(), rand_bound());
        // idling pattern switches once the phase's config is loaded
        case (ph)
          0: begin
            src_idle_pct = 19;
            snk_idle_pct = 80;
          end
          1: begin
            src_idle_pct = 80;
            snk_idle_pct = 19;
          end
          default: begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
          end
        endcase
        chunk_items = 0;
        while (chunk_items < 55) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
          for (int i = 0; i < len; i++) send_element(rand_element(i == len - 1));
          chunk_items += len;
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.pos_old = '0;
    in_bus.pos_new = '0;
    in_bus.grad = '0;
    in_bus.have_pos = 1'b0;
    in_bus.have_grad = 1'b0;
    in_bus.last = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (8) @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_saturation();
    test_random();
    quiesce();

    $display("Sent %0d vector elements; checked %0d verdicts across defaults, extremes,",
             items_sent, verdicts_checked);
    $display("saturating sums and random vectors under three idling patterns.");
    if (errors == 0) begin
      $display("optimizer_convergence_check_tb passed");
    end else begin
      $display("optimizer_convergence_check_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("optimizer_convergence_check_tb failed");
    $finish;
  end

endmodule
